/* src/ipv6_address_text_formatter_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the address text formatter
// Clocked on i_clk, switched off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef IPV6_ADDRESS_TEXT_FORMATTER_ASSERT_SVH
`define IPV6_ADDRESS_TEXT_FORMATTER_ASSERT_SVH

// Same-cycle implication
`define IPV6_FMT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define IPV6_FMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ipv6_fmt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_fmt_pkg
// Shared types, character codes and the hex digit lookup for the formatter.
// ----------------------------------------------------------------------------
package ipv6_fmt_pkg;

    // Eight 16-bit groups, group 0 in the top bits
    typedef logic [0:7][15:0] t_groups;
    // Four nibbles of one group, most significant first
    typedef logic [0:3][3:0]  t_nibbles;
    // Four bytes of the embedded IPv4 address, first byte in the top bits
    typedef logic [0:3][7:0]  t_quad;

    // Longest zero run: stop is start plus length (0 to 8)
    typedef struct packed {
        logic       found;
        logic [2:0] start;
        logic [3:0] stop;
    } t_run;

    // One character towards the output register
    typedef struct packed {
        logic       valid;
        logic [6:0] code;
        logic       last;
    } t_char;

    localparam logic [31:0] MAPPED_TAG = 32'h0000_ffff;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_COLON = 7'h3a;
    localparam logic [6:0] CH_DOT   = 7'h2e;
    localparam logic [6:0] CH_ALPHA = 7'h57;   // 'a' less ten

    localparam logic [7:0] DEC_HUNDRED = 8'd100;
    localparam logic [7:0] DEC_TEN     = 8'd10;

    // Lowercase hex digit
    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] code;
        if (nib < 4'd10) begin
            code = CH_ZERO + {3'b000, nib};
        end else begin
            code = CH_ALPHA + {3'b000, nib};
        end
        return code;
    endfunction

endpackage

/* src/ipv6_fmt_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_fmt_scan
// Walks the eight groups one per cycle and keeps the first longest run of
// two or more zero groups.
// ----------------------------------------------------------------------------
module ipv6_fmt_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  ipv6_fmt_pkg::t_groups i_groups,
    output logic                  o_done,
    output ipv6_fmt_pkg::t_run    o_run
);

    logic       r_busy;
    logic       r_done;
    logic [2:0] r_idx;
    logic [3:0] r_cur_len;
    logic [2:0] r_cur_start;
    logic [3:0] r_best_len;
    logic [2:0] r_best_start;

    logic       w_zero;
    logic [3:0] w_new_len;
    logic [2:0] w_run_start;

    // Compare the current group and extend the open run
    assign w_zero      = (i_groups[r_idx] == 16'h0000);
    assign w_new_len   = r_cur_len + 4'd1;
    assign w_run_start = (r_cur_len == 4'd0) ? r_idx : r_cur_start;

    // Control: busy while the eight groups are walked, then a one-cycle done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= 3'd0;
            end else if (r_busy) begin
                r_idx <= r_idx + 3'd1;
                if (r_idx == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Run bookkeeping; strict compare keeps the first run on a tie
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cur_len    <= 4'd0;
            r_cur_start  <= 3'd0;
            r_best_len   <= 4'd0;
            r_best_start <= 3'd0;
        end else if (r_busy) begin
            if (w_zero) begin
                r_cur_len   <= w_new_len;
                r_cur_start <= w_run_start;
                if (w_new_len >= 4'd2 && w_new_len > r_best_len) begin
                    r_best_len   <= w_new_len;
                    r_best_start <= w_run_start;
                end
            end else begin
                r_cur_len <= 4'd0;
            end
        end
    end

    assign o_done      = r_done;
    assign o_run.found = (r_best_len != 4'd0);
    assign o_run.start = r_best_start;
    assign o_run.stop  = {1'b0, r_best_start} + r_best_len;

endmodule

/* src/ipv6_fmt_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_fmt_emit
// Character sequencer: hex groups with colon and zero-run handling, or a
// dotted quad whose decimal digits come from one shared subtract unit.
// ----------------------------------------------------------------------------
module ipv6_fmt_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_mapped,
    input  logic                  i_take,
    input  ipv6_fmt_pkg::t_groups i_groups,
    input  ipv6_fmt_pkg::t_run    i_run,
    output ipv6_fmt_pkg::t_char   o_char
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SEP   = 9'b000000010,
        ST_SEP2  = 9'b000000100,
        ST_NIB   = 9'b000001000,
        ST_DLOAD = 9'b000010000,
        ST_DHUND = 9'b000100000,
        ST_DTENS = 9'b001000000,
        ST_DONES = 9'b010000000,
        ST_DOT   = 9'b100000000
    } t_emit_step;

    t_emit_step r_step, n_step;
    logic [2:0] r_idx, n_idx;
    logic [1:0] r_nib, n_nib;
    logic       r_started, n_started;
    logic [7:0] r_rem, n_rem;
    logic [3:0] r_cnt, n_cnt;

    ipv6_fmt_pkg::t_nibbles w_nibs;
    ipv6_fmt_pkg::t_quad    w_quad;
    logic [3:0]             w_nib;
    logic                   w_in_run;
    logic                   w_after_run;
    logic [7:0]             w_sub_k;
    logic                   w_sub_ge;
    logic [7:0]             w_sub_diff;
    ipv6_fmt_pkg::t_char    w_char;

    // Operand selection
    assign w_nibs      = i_groups[r_idx];
    assign w_nib       = w_nibs[r_nib];
    assign w_quad      = {i_groups[6], i_groups[7]};
    assign w_in_run    = i_run.found && (r_idx >= i_run.start)
                         && ({1'b0, r_idx} < i_run.stop);
    assign w_after_run = i_run.found && ({1'b0, r_idx} == i_run.stop);

    // Shared compare and subtract unit for decimal digits
    assign w_sub_k    = (r_step == ST_DHUND) ? ipv6_fmt_pkg::DEC_HUNDRED
                                             : ipv6_fmt_pkg::DEC_TEN;
    assign w_sub_ge   = (r_rem >= w_sub_k);
    assign w_sub_diff = r_rem - w_sub_k;

    // Step sequencer; holds while the output register is full and not being taken
    always_comb begin
        n_step    = r_step;
        n_idx     = r_idx;
        n_nib     = r_nib;
        n_started = r_started;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        w_char    = '0;
        if (r_step == ST_IDLE) begin
            if (i_start) begin
                n_step    = i_mapped ? ST_DLOAD : ST_SEP;
                n_idx     = 3'd0;
                n_nib     = 2'd0;
                n_started = 1'b0;
            end
        end else if (i_take) begin
            case (r_step)
                ST_SEP: begin
                    if (w_in_run) begin
                        w_char.valid = 1'b1;
                        w_char.code  = ipv6_fmt_pkg::CH_COLON;
                        n_step       = ST_SEP2;
                    end else begin
                        if (r_idx != 3'd0 && !w_after_run) begin
                            w_char.valid = 1'b1;
                            w_char.code  = ipv6_fmt_pkg::CH_COLON;
                        end
                        n_step    = ST_NIB;
                        n_nib     = 2'd0;
                        n_started = 1'b0;
                    end
                end
                ST_SEP2: begin
                    // second colon of the run; jump past the zero groups
                    w_char.valid = 1'b1;
                    w_char.code  = ipv6_fmt_pkg::CH_COLON;
                    w_char.last  = i_run.stop[3];
                    if (i_run.stop[3]) begin
                        n_step = ST_IDLE;
                    end else begin
                        n_idx  = i_run.stop[2:0];
                        n_step = ST_SEP;
                    end
                end
                ST_NIB: begin
                    // drop leading zero nibbles, keep the final one
                    if (w_nib != 4'd0 || r_started || r_nib == 2'd3) begin
                        w_char.valid = 1'b1;
                        w_char.code  = ipv6_fmt_pkg::hex_char(w_nib);
                        w_char.last  = (r_nib == 2'd3) && (r_idx == 3'd7);
                        n_started    = 1'b1;
                    end
                    if (r_nib == 2'd3) begin
                        if (r_idx == 3'd7) begin
                            n_step = ST_IDLE;
                        end else begin
                            n_idx  = r_idx + 3'd1;
                            n_step = ST_SEP;
                        end
                    end else begin
                        n_nib = r_nib + 2'd1;
                    end
                end
                ST_DLOAD: begin
                    n_rem     = w_quad[r_idx[1:0]];
                    n_cnt     = 4'd0;
                    n_started = 1'b0;
                    n_step    = ST_DHUND;
                end
                ST_DHUND, ST_DTENS: begin
                    if (w_sub_ge) begin
                        n_rem = w_sub_diff;
                        n_cnt = r_cnt + 4'd1;
                    end else begin
                        if (r_cnt != 4'd0 || r_started) begin
                            w_char.valid = 1'b1;
                            w_char.code  = ipv6_fmt_pkg::CH_ZERO + {3'b000, r_cnt};
                            n_started    = 1'b1;
                        end
                        n_cnt  = 4'd0;
                        n_step = (r_step == ST_DHUND) ? ST_DTENS : ST_DONES;
                    end
                end
                ST_DONES: begin
                    w_char.valid = 1'b1;
                    w_char.code  = ipv6_fmt_pkg::CH_ZERO + {3'b000, r_rem[3:0]};
                    w_char.last  = (r_idx[1:0] == 2'd3);
                    n_step       = (r_idx[1:0] == 2'd3) ? ST_IDLE : ST_DOT;
                end
                ST_DOT: begin
                    w_char.valid = 1'b1;
                    w_char.code  = ipv6_fmt_pkg::CH_DOT;
                    n_idx        = r_idx + 3'd1;
                    n_step       = ST_DLOAD;
                end
                default: begin
                    n_step = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_nib     <= n_nib;
        r_started <= n_started;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
    end

    assign o_char = w_char;

endmodule

/* src/ipv6_address_text_formatter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_address_text_formatter
// Turns one 128-bit address into its text form, one ASCII character a word.
// ----------------------------------------------------------------------------
//  Channel   Dir  Width  Contents
//  s_axis    in   128    addr_high [63:0], addr_low [127:64]
//  m_axis    out  8      char_code [6:0], zero [7]; tlast = last_char
//
//  An address is taken only while the block is idle. A zero-run scan of the
//  eight groups follows, then the sequencer gives at most one character a
//  cycle. Hex text needs up to 5 sequencer steps a group; a dotted quad
//  needs up to 15 steps a byte, since the shared subtract unit removes one
//  hundred or one ten per cycle. A stalled output holds the sequencer;
//  reset clears control state only.
// ----------------------------------------------------------------------------
`include "ipv6_address_text_formatter_assert.svh"

module ipv6_address_text_formatter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // addr_high [63:0], addr_low [127:64]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,   // char_code [6:0], zero pad [7]
    output logic         m_axis_tlast    // last_char
);

    typedef enum logic [2:0] {
        TS_IDLE = 3'b001,
        TS_SCAN = 3'b010,
        TS_EMIT = 3'b100
    } t_top_state;

    t_top_state r_state, n_state;

    ipv6_fmt_pkg::t_groups r_addr;
    logic                  r_mapped;
    logic                  r_out_valid;
    logic [6:0]            r_out_code;
    logic                  r_out_last;

    logic                  w_accept;
    logic                  w_take;
    logic                  w_scan_done;
    ipv6_fmt_pkg::t_run    w_run;
    ipv6_fmt_pkg::t_char   w_char;

    assign s_axis_tready = (r_state == TS_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_take        = !r_out_valid || m_axis_tready;

    // Capture the address and classify it
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr   <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
            r_mapped <= (s_axis_tdata[63:0] == 64'd0)
                        && (s_axis_tdata[127:96] == ipv6_fmt_pkg::MAPPED_TAG);
        end
    end

    // Top-level sequencing
    always_comb begin
        n_state = r_state;
        case (r_state)
            TS_IDLE: if (w_accept) n_state = TS_SCAN;
            TS_SCAN: if (w_scan_done) n_state = TS_EMIT;
            TS_EMIT: if (w_char.valid && w_char.last) n_state = TS_IDLE;
            default: n_state = TS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    ipv6_fmt_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_groups (r_addr),
        .o_done   (w_scan_done),
        .o_run    (w_run)
    );

    ipv6_fmt_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  ((r_state == TS_SCAN) && w_scan_done),
        .i_mapped (r_mapped),
        .i_take   (w_take),
        .i_groups (r_addr),
        .i_run    (w_run),
        .o_char   (w_char)
    );

    // Output register: load a word whenever it is free or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= w_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_char.valid) begin
            r_out_code <= w_char.code;
            r_out_last <= w_char.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_code};
    assign m_axis_tlast  = r_out_last;

    `IPV6_FMT_ASSERT_SAME(a_idle_quiet, r_state == TS_IDLE, !w_char.valid, "character while idle")
    `IPV6_FMT_ASSERT_NEXT(a_accept_scans, w_accept, r_state == TS_SCAN, "accept did not start scan")
    `IPV6_FMT_ASSERT_SAME(a_char_room, w_char.valid, w_take, "character into full output register")
    `IPV6_FMT_ASSERT_SAME(a_scan_done_state, w_scan_done, r_state == TS_SCAN, "scan done out of turn")

endmodule
